@@ hw/rtl/adl_pkg.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// adl_pkg
// Shared constants and types for the multi-byte Adler-32 engine.
// ----------------------------------------------------------------------------
package adl_pkg;

  // Number of byte lanes carried by one input beat.
  localparam int LANES = 8;

  // Widths of the input fields and the running sums.
  localparam int DATA_W  = 64;
  localparam int COUNT_W = 4;
  localparam int SUM_W   = 16;
  localparam int CSUM_W  = 32;

  // Adler-32 modulus.
  localparam logic [SUM_W-1:0] ADLER_MOD = 16'd65521;

  // Per-lane and per-beat partial sum widths.
  // Product of a weight (at most LANES) and a byte.
  localparam int PROD_W  = COUNT_W + 8;
  // Plain sum of LANES bytes: at most 8 * 255.
  localparam int PLAIN_W = 11;
  // Weighted sum: at most 36 * 255.
  localparam int WSUM_W  = 14;

  // Byte count saturation limit at the count width.
  localparam logic [COUNT_W-1:0] LANES_N = COUNT_W'(LANES);

  // Partial sums of one beat, passed from the lane stage to the accumulator.
  typedef struct packed {
    logic               valid;
    logic               last;
    logic [COUNT_W-1:0] count;
    logic [PLAIN_W-1:0] plain;
    logic [WSUM_W-1:0]  weighted;
  } adl_beat_t;

endpackage

@@ hw/rtl/adl_lane.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// adl_lane
// One byte lane: masks the byte by the valid count and weights it by the
// number of running s1 values that it reaches within the beat.
// ----------------------------------------------------------------------------
module adl_lane
  import adl_pkg::*;
(
  input  logic [7:0]         lane_byte,
  input  logic [COUNT_W-1:0] lane_idx,
  input  logic [COUNT_W-1:0] count,
  output logic [7:0]         plain,
  output logic [PROD_W-1:0]  weighted
);

  logic               active;
  logic [COUNT_W-1:0] weight;

  // A lane takes part only below the valid byte count.
  assign active = (lane_idx < count);
  assign weight = count - lane_idx;

  // Byte i is counted into s2 once for each of the n - i following s1 updates.
  assign plain    = active ? lane_byte : 8'd0;
  assign weighted = active ? (PROD_W'(weight) * PROD_W'(lane_byte)) : '0;

endmodule

@@ hw/rtl/adl_fold.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// adl_fold
// Lane stage: runs all byte lanes side by side, adds their plain and
// weighted contributions and registers the partial sums of the beat.
// ----------------------------------------------------------------------------
module adl_fold
  import adl_pkg::*;
(
  input  logic               clk,
  input  logic               rst_n,
  input  logic               in_valid,
  output logic               in_ready,
  input  logic [DATA_W-1:0]  in_data_bytes,
  input  logic [COUNT_W-1:0] in_byte_count,
  input  logic               in_last,
  output adl_beat_t          beat,
  input  logic               beat_ready
);

  logic [COUNT_W-1:0] count_sat;
  logic [7:0]         lane_plain [LANES];
  logic [PROD_W-1:0]  lane_wsum  [LANES];
  logic [PLAIN_W-1:0] plain_sum;
  logic [WSUM_W-1:0]  wsum_sum;
  adl_beat_t          beat_r;
  adl_beat_t          beat_nxt;

  // Counts above the lane count are clipped to it.
  assign count_sat = (in_byte_count > LANES_N) ? LANES_N : in_byte_count;

  // One lane per byte of the beat.
  for (genvar g = 0; g < LANES; g++) begin : g_lane
    adl_lane u_lane (
      .lane_byte (in_data_bytes[8*g +: 8]),
      .lane_idx  (COUNT_W'(g)),
      .count     (count_sat),
      .plain     (lane_plain[g]),
      .weighted  (lane_wsum[g])
    );
  end

  // Add the lane contributions.
  always_comb begin
    plain_sum = '0;
    wsum_sum  = '0;
    for (int i = 0; i < LANES; i++) begin
      plain_sum = plain_sum + PLAIN_W'(lane_plain[i]);
      wsum_sum  = wsum_sum + WSUM_W'(lane_wsum[i]);
    end
  end

  // The stage takes a new beat when empty or when its beat moves on.
  assign in_ready = !beat_r.valid || beat_ready;

  always_comb begin
    beat_nxt = beat_r;
    if (in_ready) begin
      beat_nxt.valid    = in_valid;
      beat_nxt.last     = in_last;
      beat_nxt.count    = count_sat;
      beat_nxt.plain    = plain_sum;
      beat_nxt.weighted = wsum_sum;
    end
  end

  // Stage register, cleared by reset.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      beat_r <= '0;
    end else begin
      beat_r <= beat_nxt;
    end
  end

  assign beat = beat_r;

endmodule

@@ hw/rtl/adl_acc.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// adl_acc
// Merge stage: folds the partial sums of one beat into s1 and s2 modulo
// 65521, holds the seed, and registers the checksum on the last beat.
// ----------------------------------------------------------------------------
module adl_acc
  import adl_pkg::*;
(
  input  logic              clk,
  input  logic              rst_n,
  input  logic              cfg_we,
  input  logic [CSUM_W-1:0] cfg_wdata,
  input  adl_beat_t         beat,
  output logic              beat_ready,
  output logic              out_valid,
  input  logic              out_ready,
  output logic [CSUM_W-1:0] out_checksum
);

  // Reduce a value below twice the modulus.
  function automatic logic [SUM_W-1:0] mod_once(input logic [SUM_W:0] x);
    logic [SUM_W:0] d;
    d = x - {1'b0, ADLER_MOD};
    mod_once = (x >= {1'b0, ADLER_MOD}) ? d[SUM_W-1:0] : x[SUM_W-1:0];
  endfunction

  localparam int ACC_W = SUM_W + COUNT_W;

  logic [SUM_W-1:0]  seed_a_r, seed_a_nxt;
  logic [SUM_W-1:0]  seed_b_r, seed_b_nxt;
  logic [SUM_W-1:0]  sum_a_r, sum_a_nxt;
  logic [SUM_W-1:0]  sum_b_r, sum_b_nxt;
  logic              out_valid_r, out_valid_nxt;
  logic [CSUM_W-1:0] out_checksum_r, out_checksum_nxt;
  logic              fire;
  logic [ACC_W-1:0]  b_raw;
  logic [SUM_W:0]    b_fold;
  logic [SUM_W-1:0]  a_upd;
  logic [SUM_W-1:0]  b_upd;

  // A last beat waits until the output register is free.
  assign beat_ready = !beat.last || !out_valid_r || out_ready;
  assign fire       = beat.valid && beat_ready;

  // s2 + n * s1 + weighted, then fold with 2^16 = 15 mod 65521.
  assign b_raw  = ACC_W'(sum_b_r) + ACC_W'(beat.count) * ACC_W'(sum_a_r)
                + ACC_W'(beat.weighted);
  assign b_fold = (SUM_W+1)'(b_raw[SUM_W-1:0])
                + (SUM_W+1)'(b_raw[ACC_W-1:SUM_W]) * (SUM_W+1)'(15);
  assign b_upd  = mod_once(b_fold);
  assign a_upd  = mod_once((SUM_W+1)'(sum_a_r) + (SUM_W+1)'(beat.plain));

  // Next state of sums, seed and output register.
  always_comb begin
    seed_a_nxt       = seed_a_r;
    seed_b_nxt       = seed_b_r;
    sum_a_nxt        = sum_a_r;
    sum_b_nxt        = sum_b_r;
    out_checksum_nxt = out_checksum_r;
    out_valid_nxt    = out_valid_r && !out_ready;
    if (cfg_we) begin
      seed_a_nxt = mod_once({1'b0, cfg_wdata[SUM_W-1:0]});
      seed_b_nxt = mod_once({1'b0, cfg_wdata[CSUM_W-1:SUM_W]});
      sum_a_nxt  = seed_a_nxt;
      sum_b_nxt  = seed_b_nxt;
    end else if (fire) begin
      if (beat.last) begin
        out_checksum_nxt = {b_upd, a_upd};
        out_valid_nxt    = 1'b1;
        sum_a_nxt        = seed_a_r;
        sum_b_nxt        = seed_b_r;
      end else begin
        sum_a_nxt = a_upd;
        sum_b_nxt = b_upd;
      end
    end
  end

  // Reset loads the default seed of 1.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      seed_a_r    <= 16'd1;
      seed_b_r    <= 16'd0;
      sum_a_r     <= 16'd1;
      sum_b_r     <= 16'd0;
      out_valid_r <= 1'b0;
    end else begin
      seed_a_r    <= seed_a_nxt;
      seed_b_r    <= seed_b_nxt;
      sum_a_r     <= sum_a_nxt;
      sum_b_r     <= sum_b_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  // Checksum payload register.
  always_ff @(posedge clk) begin
    out_checksum_r <= out_checksum_nxt;
  end

  assign out_valid    = out_valid_r;
  assign out_checksum = out_checksum_r;

endmodule

@@ hw/rtl/adler32_multibyte_top.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// adler32_multibyte_top
// Path: the last beat is registered in the lane stage, then out_valid and
// the checksum in the merge stage; a full output register can hold it back.
// Throughput: one beat of up to eight bytes per cycle unless a last beat
// waits for the output register; the merge stage s1/s2 update loop sets it.
// Reset: synchronous, active low; seed returns to 1, s1 = 1 and s2 = 0.
// ----------------------------------------------------------------------------
module adler32_multibyte_top
  import adl_pkg::*;
(
  input  logic               clk,
  input  logic               rst_n,
  input  logic               cfg_we,
  input  logic [CSUM_W-1:0]  cfg_wdata,
  input  logic               in_valid,
  output logic               in_ready,
  input  logic [DATA_W-1:0]  in_data_bytes,
  input  logic [COUNT_W-1:0] in_byte_count,
  input  logic               in_last,
  output logic               out_valid,
  input  logic               out_ready,
  output logic [CSUM_W-1:0]  out_checksum
);

  adl_beat_t beat;
  logic      beat_ready;

  // Parallel lane stage.
  adl_fold u_fold (
    .clk           (clk),
    .rst_n         (rst_n),
    .in_valid      (in_valid),
    .in_ready      (in_ready),
    .in_data_bytes (in_data_bytes),
    .in_byte_count (in_byte_count),
    .in_last       (in_last),
    .beat          (beat),
    .beat_ready    (beat_ready)
  );

  // Running sums and checksum output.
  adl_acc u_acc (
    .clk          (clk),
    .rst_n        (rst_n),
    .cfg_we       (cfg_we),
    .cfg_wdata    (cfg_wdata),
    .beat         (beat),
    .beat_ready   (beat_ready),
    .out_valid    (out_valid),
    .out_ready    (out_ready),
    .out_checksum (out_checksum)
  );

endmodule
